// ===== rtl/block_rms_calculator_defines.svh =====
// ----------------------------------------------------------------------------
// block_rms_calculator_defines.svh
// Assertion macros used by the block RMS calculator back end (brms_back).
// ----------------------------------------------------------------------------
`ifndef BLOCK_RMS_CALCULATOR_DEFINES_SVH
`define BLOCK_RMS_CALCULATOR_DEFINES_SVH

// pre holds in a cycle -> post holds in the same cycle
`define BRMS_ASSERT_SAME(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("block_rms_calculator same-cycle check failed");

// pre holds in a cycle -> post holds in the next cycle
`define BRMS_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("block_rms_calculator next-cycle check failed");

`endif

// ===== rtl/brms_pkg.sv =====
// ----------------------------------------------------------------------------
// brms_pkg
// Widths, types and state codes of the block RMS calculator.
// ----------------------------------------------------------------------------
package brms_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_BITS  = 16;
    localparam int SUM_BITS    = 2 * SAMPLE_BITS + COUNT_BITS - 1;
    // a mean never exceeds the largest square, 2^(2*SAMPLE_BITS-2)
    localparam int MEAN_BITS   = 2 * SAMPLE_BITS - 1;
    localparam int ROOT_BITS   = SAMPLE_BITS;
    localparam int RAD_BITS    = 2 * ROOT_BITS;
    // root remainder width
    localparam int SREM_BITS   = ROOT_BITS + 2;
    localparam int STEP_BITS   = $clog2(SUM_BITS);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QFILL_BITS  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COUNT_BITS-1:0] LEN_RESET = COUNT_BITS'(256);

    // one finished block, handed from the front end to the back end
    typedef struct packed {
        logic [SUM_BITS-1:0]   sum;
        logic [COUNT_BITS-1:0] count;
    } block_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_SQRT = 3'b100
    } back_state_t;

endpackage

// ===== rtl/block_rms_calculator.sv =====
// ----------------------------------------------------------------------------
// block_rms_calculator
// Block RMS of a Q15 sample stream: floor(sqrt(floor(sum of squares / n))).
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while in_stall is low; squaring and
// accumulation run in a two-stage front end. When block_length samples
// have been summed (zero counts as one), the sum and count go into a
// two-entry queue. The back end takes one block at a time: it loads the
// block, runs a bit-serial division and then a square root. That back-end
// time per block sets the sustained rate: the input stalls when the queue
// holds two pending blocks and a third one closes, which short blocks or
// a stalled output can bring about.
// block_length is written through cfg_valid/cfg_ready (always ready) and
// takes effect for the next sample; a value at or below the current count
// closes the block on the next sample.
module block_rms_calculator (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [brms_pkg::SAMPLE_BITS-1:0] sample,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [brms_pkg::SAMPLE_BITS-1:0]        rms_value,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [brms_pkg::COUNT_BITS-1:0]         block_length
);

    logic             push_valid;
    brms_pkg::block_t push_data;
    logic             q_full;
    logic             q_valid;
    logic             pop;
    brms_pkg::block_t head;

    assign cfg_ready = 1'b1;

    brms_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .cfg_valid    (cfg_valid),
        .block_length (block_length),
        .push_valid   (push_valid),
        .push_data    (push_data),
        .q_full       (q_full)
    );

    brms_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .q_full     (q_full),
        .q_valid    (q_valid),
        .pop        (pop),
        .head       (head)
    );

    brms_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .rms_value (rms_value)
    );

endmodule

// ===== rtl/brms_front.sv =====
// ----------------------------------------------------------------------------
// brms_front
// Takes samples, squares them, accumulates the block sum and count, and
// pushes each finished block into the queue.
// ----------------------------------------------------------------------------
module brms_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [brms_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                cfg_valid,
    input  logic [brms_pkg::COUNT_BITS-1:0]     block_length,
    output logic                                push_valid,
    output brms_pkg::block_t                    push_data,
    input  logic                                q_full
);

    logic [brms_pkg::COUNT_BITS-1:0]   len_reg;
    logic [brms_pkg::COUNT_BITS-1:0]   count_reg;
    logic [brms_pkg::SUM_BITS-1:0]     sum_reg;
    logic                              sq_valid_reg;
    logic                              sq_end_reg;
    logic [brms_pkg::MEAN_BITS-1:0]    sq_reg;
    logic [brms_pkg::COUNT_BITS-1:0]   sq_count_reg;

    logic                              accept;
    logic                              stuck;
    logic [brms_pkg::COUNT_BITS-1:0]   len_eff;
    logic [brms_pkg::COUNT_BITS:0]     count_inc;
    logic                              block_end;
    logic signed [2*brms_pkg::SAMPLE_BITS-1:0] product;
    logic [brms_pkg::SUM_BITS-1:0]     sum_next;

    // a zero length behaves as one
    assign len_eff   = (len_reg == '0) ? brms_pkg::COUNT_BITS'(1) : len_reg;
    assign count_inc = {1'b0, count_reg} + (brms_pkg::COUNT_BITS+1)'(1);
    assign block_end = count_inc >= {1'b0, len_eff};

    assign product   = sample * sample;

    // stage 2 only holds when a finished block finds the queue full
    assign stuck     = sq_valid_reg && sq_end_reg && q_full;
    assign in_stall  = stuck;
    assign accept    = in_valid && !stuck;

    assign sum_next  = sum_reg + brms_pkg::SUM_BITS'(sq_reg);

    assign push_valid      = sq_valid_reg && sq_end_reg && !q_full;
    assign push_data.sum   = sum_next;
    assign push_data.count = sq_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= brms_pkg::LEN_RESET;
            count_reg    <= '0;
            sum_reg      <= '0;
            sq_valid_reg <= 1'b0;
            sq_end_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                len_reg <= block_length;
            end

            if (sq_valid_reg && !stuck)
            begin
                sum_reg <= sq_end_reg ? '0 : sum_next;
            end

            if (accept)
            begin
                count_reg    <= block_end ? '0 : count_inc[brms_pkg::COUNT_BITS-1:0];
                sq_valid_reg <= 1'b1;
                sq_end_reg   <= block_end;
            end
            else if (!stuck)
            begin
                sq_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sq_reg       <= product[brms_pkg::MEAN_BITS-1:0];
            sq_count_reg <= count_inc[brms_pkg::COUNT_BITS-1:0];
        end
    end

endmodule

// ===== rtl/brms_queue.sv =====
// ----------------------------------------------------------------------------
// brms_queue
// Short FIFO of finished blocks between the front end and the back end.
// ----------------------------------------------------------------------------
module brms_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    input  brms_pkg::block_t push_data,
    output logic             q_full,
    output logic             q_valid,
    input  logic             pop,
    output brms_pkg::block_t head
);

    brms_pkg::block_t                 entry_reg [brms_pkg::QUEUE_DEPTH];
    logic [brms_pkg::QPTR_BITS-1:0]   wr_ptr_reg;
    logic [brms_pkg::QPTR_BITS-1:0]   rd_ptr_reg;
    logic [brms_pkg::QFILL_BITS-1:0]  fill_reg;

    logic do_push;
    logic do_pop;

    assign q_full  = fill_reg == brms_pkg::QFILL_BITS'(brms_pkg::QUEUE_DEPTH);
    assign q_valid = fill_reg != '0;
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push_valid && !q_full;
    assign do_pop  = pop && q_valid;

    function automatic logic [brms_pkg::QPTR_BITS-1:0] ptr_inc(
        input logic [brms_pkg::QPTR_BITS-1:0] p
    );
        if (p == brms_pkg::QPTR_BITS'(brms_pkg::QUEUE_DEPTH - 1))
            return '0;
        return p + brms_pkg::QPTR_BITS'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + brms_pkg::QFILL_BITS'(1);
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - brms_pkg::QFILL_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/brms_back.sv =====
// ----------------------------------------------------------------------------
// brms_back
// Per block: restoring divide of the sum by the count, one quotient bit a
// cycle, then a digit-by-digit square root, two radicand bits a cycle, its last step waiting while a result is held.
// ----------------------------------------------------------------------------
`include "block_rms_calculator_defines.svh"

module brms_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_valid,
    input  brms_pkg::block_t                   head,
    output logic                               pop,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [brms_pkg::SAMPLE_BITS-1:0]   rms_value
);

    brms_pkg::back_state_t             state_reg, state_next;
    logic [brms_pkg::STEP_BITS-1:0]    step_reg;
    logic [brms_pkg::SUM_BITS-1:0]     quo_reg;
    logic [brms_pkg::COUNT_BITS-1:0]   rem_reg;
    logic [brms_pkg::COUNT_BITS-1:0]   div_reg;
    logic [brms_pkg::RAD_BITS-1:0]     rad_reg;
    logic [brms_pkg::SREM_BITS-1:0]    srem_reg;
    logic [brms_pkg::ROOT_BITS-1:0]    root_reg;
    logic                              out_valid_reg;
    logic [brms_pkg::SAMPLE_BITS-1:0]  rms_value_reg;

    logic [brms_pkg::COUNT_BITS:0]     div_shift;
    logic                              div_ge;
    logic [brms_pkg::COUNT_BITS:0]     div_sub;
    logic [brms_pkg::SREM_BITS+1:0]    sq_shift;
    logic [brms_pkg::SREM_BITS+1:0]    sq_trial;
    logic                              sq_ge;
    logic [brms_pkg::SREM_BITS+1:0]    sq_sub;
    logic [brms_pkg::ROOT_BITS-1:0]    root_next;
    logic                              out_busy;
    logic                              last_step;
    logic                              sq_hold;
    logic                              res_load;

    assign out_busy  = out_valid_reg && out_stall;
    assign last_step = step_reg == '0;

    assign div_shift = {rem_reg, quo_reg[brms_pkg::SUM_BITS-1]};
    assign div_ge    = div_shift >= {1'b0, div_reg};
    assign div_sub   = div_shift - {1'b0, div_reg};

    assign sq_shift  = {srem_reg, rad_reg[brms_pkg::RAD_BITS-1 -: 2]};
    assign sq_trial  = {(brms_pkg::SREM_BITS-brms_pkg::ROOT_BITS)'(0), root_reg, 2'b01};
    assign sq_ge     = sq_shift >= sq_trial;
    assign sq_sub    = sq_shift - sq_trial;
    assign root_next = {root_reg[brms_pkg::ROOT_BITS-2:0], sq_ge};

    // the last root step waits while the previous result is still held
    assign sq_hold   = last_step && out_busy;
    assign res_load  = (state_reg == brms_pkg::ST_SQRT) && last_step && !sq_hold;

    assign pop       = (state_reg == brms_pkg::ST_IDLE) && q_valid;
    assign out_valid = out_valid_reg;
    assign rms_value = rms_value_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            brms_pkg::ST_IDLE:
            begin
                if (q_valid)
                    state_next = brms_pkg::ST_DIV;
            end
            brms_pkg::ST_DIV:
            begin
                if (last_step)
                    state_next = brms_pkg::ST_SQRT;
            end
            brms_pkg::ST_SQRT:
            begin
                if (last_step && !out_busy)
                    state_next = brms_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = brms_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= brms_pkg::ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                brms_pkg::ST_IDLE:
                begin
                    step_reg <= brms_pkg::STEP_BITS'(brms_pkg::SUM_BITS - 1);
                end
                brms_pkg::ST_DIV:
                begin
                    step_reg <= last_step ? brms_pkg::STEP_BITS'(brms_pkg::ROOT_BITS - 1)
                                          : step_reg - brms_pkg::STEP_BITS'(1);
                end
                brms_pkg::ST_SQRT:
                begin
                    if (!sq_hold && !last_step)
                        step_reg <= step_reg - brms_pkg::STEP_BITS'(1);
                end
                default:
                begin
                    step_reg <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            brms_pkg::ST_IDLE:
            begin
                quo_reg <= head.sum;
                div_reg <= head.count;
                rem_reg <= '0;
            end
            brms_pkg::ST_DIV:
            begin
                quo_reg <= {quo_reg[brms_pkg::SUM_BITS-2:0], div_ge};
                rem_reg <= div_ge ? div_sub[brms_pkg::COUNT_BITS-1:0]
                                  : div_shift[brms_pkg::COUNT_BITS-1:0];
                if (last_step)
                begin
                    // the full quotient lands in quo_reg only after this step; take it from
                    // the final shift so the root can start at once
                    rad_reg  <= brms_pkg::RAD_BITS'(
                        {quo_reg[brms_pkg::MEAN_BITS-2:0], div_ge});
                    srem_reg <= '0;
                    root_reg <= '0;
                end
            end
            brms_pkg::ST_SQRT:
            begin
                if (!sq_hold)
                begin
                    rad_reg  <= {rad_reg[brms_pkg::RAD_BITS-3:0], 2'b00};
                    srem_reg <= sq_ge ? sq_sub[brms_pkg::SREM_BITS-1:0]
                                      : sq_shift[brms_pkg::SREM_BITS-1:0];
                    root_reg <= root_next;
                    if (last_step)
                        rms_value_reg <= root_next;
                end
            end
            default:
            begin
                rem_reg <= '0;
            end
        endcase
    end

    `BRMS_ASSERT_SAME(a_div_nonzero, state_reg == brms_pkg::ST_DIV, div_reg != '0)
    `BRMS_ASSERT_SAME(a_rem_below_div, state_reg == brms_pkg::ST_DIV, rem_reg < div_reg)
    `BRMS_ASSERT_NEXT(a_result_loaded, state_reg == brms_pkg::ST_SQRT && last_step && !out_busy, out_valid_reg && state_reg == brms_pkg::ST_IDLE)

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for block_rms_calculator.
// ----------------------------------------------------------------------------
// A scoreboard tracks the block length, sample count and sum of squares.
// For every accepted sample item it predicts the RMS result that the item
// causes, if any. Every accepted output item is compared with the oldest
// prediction. Stimulus begins with a short directed set: extreme samples,
// a zero length, the longest length, and lengths lowered mid-block. Random
// phases follow, each with a block length from a list and one of four
// mixes of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------

class rms_scoreboard;

    logic [brms_pkg::COUNT_BITS-1:0]  len_reg;
    logic [brms_pkg::COUNT_BITS-1:0]  count;
    logic [brms_pkg::SUM_BITS-1:0]    sum;
    logic [brms_pkg::SAMPLE_BITS-1:0] rms_q[$];
    int                               errors;
    int                               samples_seen;
    int                               results_seen;

    function new();
        len_reg      = brms_pkg::LEN_RESET;
        count        = '0;
        sum          = '0;
        errors       = 0;
        samples_seen = 0;
        results_seen = 0;
    endfunction

    function void set_length(input logic [brms_pkg::COUNT_BITS-1:0] v);
        len_reg = v;
    endfunction

    // largest root with root*root <= v, one bit at a time from the top
    static function longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = brms_pkg::SAMPLE_BITS; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    function void note_sample(input logic signed [brms_pkg::SAMPLE_BITS-1:0] s);
        longint          mag;
        longint unsigned sq;
        longint unsigned total;
        longint unsigned limit;
        longint unsigned len;
        mag = s;
        if (mag < 0)
            mag = -mag;
        sq    = mag * mag;
        limit = (64'd1 << brms_pkg::SUM_BITS) - 1;
        // zero length behaves as one
        len   = (len_reg == '0) ? 1 : len_reg;
        if (count != '1)
            count = count + 1'b1;
        total = sum;
        if (sq > limit - total)
            total = limit;
        else
            total = total + sq;
        sum = total[brms_pkg::SUM_BITS-1:0];
        samples_seen++;
        // >= so that a length lowered below the count closes on this item
        if (count >= len)
        begin
            rms_q.push_back(brms_pkg::SAMPLE_BITS'(int_sqrt(total / count)));
            sum   = '0;
            count = '0;
        end
    endfunction

    function void check_result(input logic [brms_pkg::SAMPLE_BITS-1:0] got);
        logic [brms_pkg::SAMPLE_BITS-1:0] want;
        results_seen++;
        if (rms_q.size() == 0)
        begin
            $error("rms_value: unexpected result, expected none, actual %0d", got);
            errors++;
        end
        else
        begin
            want = rms_q.pop_front();
            if (got !== want)
            begin
                $error("rms_value mismatch: expected %0d, actual %0d", want, got);
                errors++;
            end
        end
    endfunction

    function int pending();
        return rms_q.size();
    endfunction

endclass

module testbench;

    localparam int  CLK_PERIOD   = 20;
    localparam int  RESET_CYCLES = 10;
    // leave the back end ample margin to finish its blocks
    localparam int  DRAIN_CYCLES = 200;
    localparam int  PHASES       = 8;
    localparam int  PHASE_ITEMS  = 50;
    localparam int  LONG_ITEMS   = 300;
    localparam time RUN_LIMIT    = 20_000_000;

    logic                                    clk          = 1'b0;
    logic                                    rst_n        = 1'b0;
    logic                                    in_valid     = 1'b0;
    logic                                    in_stall;
    logic signed [brms_pkg::SAMPLE_BITS-1:0] sample       = '0;
    logic                                    out_valid;
    logic                                    out_stall    = 1'b0;
    logic [brms_pkg::SAMPLE_BITS-1:0]        rms_value;
    logic                                    cfg_valid    = 1'b0;
    logic                                    cfg_ready;
    logic [brms_pkg::COUNT_BITS-1:0]         block_length = '0;

    rms_scoreboard sb = new();

    int send_gap_pct = 0;
    int stall_pct    = 0;
    int len_writes   = 0;

    block_rms_calculator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .rms_value    (rms_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .block_length (block_length)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_sample(sample);
            if (out_valid && !out_stall)
                sb.check_result(rms_value);
        end
    end

    task automatic send_sample(input logic signed [brms_pkg::SAMPLE_BITS-1:0] v);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_gap_pct)
            gap++;
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        sample   <= v;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic end_samples();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // no results owed and the pipeline given time to settle
    task automatic wait_idle();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(input logic [brms_pkg::COUNT_BITS-1:0] v);
        wait_idle();
        @(negedge clk);
        cfg_valid    <= 1'b1;
        block_length <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_length(v);
        len_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [brms_pkg::SAMPLE_BITS-1:0] rand_sample();
        unique case ($urandom_range(7))
            0:       return -16'sd32768;
            1:       return 16'sd32767;
            2:       return $signed(16'($urandom_range(31))) - 16'sd16;
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        #(RUN_LIMIT);
        $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        logic [brms_pkg::COUNT_BITS-1:0] lens[PHASES];
        int                              n_items;

        lens = '{16'd1, 16'd4, 16'd0, 16'd16, 16'd3, 16'd256, 16'd9, 16'd2};
        lens[6] = 16'($urandom_range(5, 40));

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset length of 256 leaves these items open
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        send_sample(-16'sd1);
        send_sample(16'sd0);
        send_sample(16'sd1);
        end_samples();
        // lowered below the count: next item closes the block of six
        write_length(16'd1);
        send_sample(16'sh4000);
        send_sample(-16'sd32768);
        send_sample(16'sd32767);
        send_sample(16'sd0);
        send_sample(-16'sd1);
        send_sample(16'sh5555);
        send_sample(-16'sh5556);
        end_samples();
        write_length(16'd0);
        send_sample(16'sd100);
        send_sample(-16'sd200);
        end_samples();
        write_length(16'hFFFF);
        send_sample(-16'sd32768);
        send_sample(-16'sd32768);
        send_sample(16'sd12345);
        end_samples();
        write_length(16'd2);
        send_sample(16'sd7);
        end_samples();
        write_length(16'd3);
        repeat (3) send_sample(-16'sd32768);
        end_samples();

        for (int p = 0; p < PHASES; p++)
        begin
            write_length(lens[p]);
            unique case (p % 4)
                0:       begin send_gap_pct = 0;  stall_pct = 0;  end
                1:       begin send_gap_pct = 48; stall_pct = 0;  end
                2:       begin send_gap_pct = 0;  stall_pct = 48; end
                default: begin send_gap_pct = 16; stall_pct = 16; end
            endcase
            n_items = (lens[p] > 16'd64) ? LONG_ITEMS : PHASE_ITEMS;
            repeat (n_items) send_sample(rand_sample());
            end_samples();
        end

        wait_idle();
        $display("Run covered %0d sample items and %0d RMS results", sb.samples_seen,
                 sb.results_seen);
        $display("over %0d block length writes, from zero up to 65535, with gaps and stalls",
                 len_writes);
        if (sb.errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
